@@ design/owm_pkg.sv @@
package owm_pkg;

   // Field widths
   localparam int CFG_WIDTH     = 10;
   localparam int OP_WIDTH      = 2;
   localparam int BYTE_WIDTH    = 8;
   localparam int BIT_IDX_WIDTH = 3;
   localparam int PHASE_WIDTH   = 3;
   localparam int CSR_IDX_WIDTH = 4;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   // Operation codes carried in req_tuser
   localparam logic [OP_WIDTH-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_RESET = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_WRITE = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd3;

   // Sequencer phases
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE       = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_RST_LOW    = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_RST_WAIT   = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_RST_TAIL   = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_SLOT_START = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_SLOT_MID   = 3'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_READ_TAIL  = 3'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_RECOVER    = 3'd7;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RESET_LOW     = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRESENCE_WAIT = 4'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RESET_TAIL    = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WRITE_START   = 4'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WRITE_HOLD    = 4'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_READ_START    = 4'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_READ_SAMPLE   = 4'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_READ_TAIL     = 4'd7;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW     = 10'd500;
   localparam logic [CFG_WIDTH-1:0] RST_PRESENCE_WAIT = 10'd70;
   localparam logic [CFG_WIDTH-1:0] RST_RESET_TAIL    = 10'd500;
   localparam logic [CFG_WIDTH-1:0] RST_WRITE_START   = 10'd10;
   localparam logic [CFG_WIDTH-1:0] RST_WRITE_HOLD    = 10'd50;
   localparam logic [CFG_WIDTH-1:0] RST_READ_START    = 10'd5;
   localparam logic [CFG_WIDTH-1:0] RST_READ_SAMPLE   = 10'd5;
   localparam logic [CFG_WIDTH-1:0] RST_READ_TAIL     = 10'd50;

   typedef logic [CFG_WIDTH-1:0] cfg_word_type;

   typedef struct packed {
      cfg_word_type reset_low;
      cfg_word_type presence_wait;
      cfg_word_type reset_tail;
      cfg_word_type write_start;
      cfg_word_type write_hold;
      cfg_word_type read_start;
      cfg_word_type read_sample;
      cfg_word_type read_tail;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic                  rejected;
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  presence_level;
      logic                  done_res;
      logic                  busy_res;
      logic                  line_low;
   } result_type;

endpackage

@@ design/owm_csr.sv @@
module owm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [owm_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [owm_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output owm_pkg::cfg_type                   cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low     = csr_wdata;
            REG_PRESENCE_WAIT: cfg_in.presence_wait = csr_wdata;
            REG_RESET_TAIL:    cfg_in.reset_tail    = csr_wdata;
            REG_WRITE_START:   cfg_in.write_start   = csr_wdata;
            REG_WRITE_HOLD:    cfg_in.write_hold    = csr_wdata;
            REG_READ_START:    cfg_in.read_start    = csr_wdata;
            REG_READ_SAMPLE:   cfg_in.read_sample   = csr_wdata;
            REG_READ_TAIL:     cfg_in.read_tail     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= RST_RESET_LOW;
         cfg_ff.presence_wait <= RST_PRESENCE_WAIT;
         cfg_ff.reset_tail    <= RST_RESET_TAIL;
         cfg_ff.write_start   <= RST_WRITE_START;
         cfg_ff.write_hold    <= RST_WRITE_HOLD;
         cfg_ff.read_start    <= RST_READ_START;
         cfg_ff.read_sample   <= RST_READ_SAMPLE;
         cfg_ff.read_tail     <= RST_READ_TAIL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/owm_seq.sv @@
module owm_seq #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic [owm_pkg::OP_WIDTH-1:0]      op,
   input  logic [owm_pkg::BYTE_WIDTH-1:0]    tx_byte,
   input  logic                              bus_level,
   input  owm_pkg::cfg_type                  cfg,
   output owm_pkg::result_type               result
);
   import owm_pkg::*;

   localparam int LenWidth = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [LenWidth-1:0] CntMax = LenWidth'((1 << COUNT_WIDTH) - 1);

   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]   tick_ff, tick_in;
   logic [BIT_IDX_WIDTH-1:0] bit_ff, bit_in;
   logic [BYTE_WIDTH-1:0]    shift_ff, shift_in;
   logic [OP_WIDTH-1:0]      kind_ff, kind_in;
   logic                     pres_ff, pres_in;
   logic [BYTE_WIDTH-1:0]    rx_ff, rx_in;

   cfg_word_type             len_raw;
   logic [LenWidth-1:0]      len_wide;
   logic [LenWidth-1:0]      len_sat;
   logic [COUNT_WIDTH-1:0]   len_cut;
   logic [COUNT_WIDTH-1:0]   phase_len;
   logic [COUNT_WIDTH-1:0]   cnt_inc;
   logic                     done;
   logic                     rej;
   logic                     is_write;

   assign is_write = (kind_ff == OP_WRITE);

   // Length of the current phase from the timing registers
   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:    len_raw = cfg.reset_low;
         PH_RST_WAIT:   len_raw = cfg.presence_wait;
         PH_RST_TAIL:   len_raw = cfg.reset_tail;
         PH_SLOT_START: len_raw = is_write ? cfg.write_start : cfg.read_start;
         PH_SLOT_MID:   len_raw = is_write ? cfg.write_hold : cfg.read_sample;
         PH_READ_TAIL:  len_raw = cfg.read_tail;
         default:       len_raw = CFG_WIDTH'(1);
      endcase
   end

   // Saturate to the counter range, zero counts as one
   always_comb begin
      len_wide  = LenWidth'(len_raw);
      len_sat   = (len_wide > CntMax) ? CntMax : len_wide;
      len_cut   = len_sat[COUNT_WIDTH-1:0];
      phase_len = (len_cut == '0) ? COUNT_WIDTH'(1) : len_cut;
   end

   assign cnt_inc = tick_ff + COUNT_WIDTH'(1);

   // Next state for one transaction
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      kind_in  = kind_ff;
      pres_in  = pres_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (item_valid) begin
         if (op != OP_TICK) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               tick_in = '0;
               bit_in  = '0;
               kind_in = op;
               if (op == OP_RESET) begin
                  phase_in = PH_RST_LOW;
               end else begin
                  shift_in = (op == OP_WRITE) ? tx_byte : '0;
                  phase_in = PH_SLOT_START;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            tick_in = cnt_inc;
            if (cnt_inc >= phase_len) begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_RST_LOW:    phase_in = PH_RST_WAIT;
                  PH_RST_WAIT: begin
                     pres_in  = bus_level;
                     phase_in = PH_RST_TAIL;
                  end
                  PH_RST_TAIL: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_SLOT_START: phase_in = PH_SLOT_MID;
                  PH_SLOT_MID: begin
                     if (is_write) begin
                        phase_in = PH_RECOVER;
                     end else begin
                        shift_in = shift_ff | (BYTE_WIDTH'(bus_level) << bit_ff);
                        phase_in = PH_READ_TAIL;
                     end
                  end
                  PH_READ_TAIL:  phase_in = PH_RECOVER;
                  PH_RECOVER: begin
                     if (bit_ff == BIT_IDX_WIDTH'(BYTE_WIDTH - 1)) begin
                        if (kind_ff == OP_READ) begin
                           rx_in = shift_ff;
                        end
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + BIT_IDX_WIDTH'(1);
                        phase_in = PH_SLOT_START;
                     end
                  end
                  default:       phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   // Result reflects the state left by this transaction
   always_comb begin
      result.rejected       = rej;
      result.rx_byte        = rx_in;
      result.presence_level = pres_in;
      result.done_res       = done;
      result.busy_res       = (phase_in != PH_IDLE);
      result.line_low       = (phase_in == PH_RST_LOW) || (phase_in == PH_SLOT_START) ||
                              ((phase_in == PH_SLOT_MID) && (kind_in == OP_WRITE) &&
                               !shift_in[bit_in]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         kind_ff  <= '0;
         pres_ff  <= 1'b1;
         rx_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         kind_ff  <= kind_in;
         pres_ff  <= pres_in;
         rx_ff    <= rx_in;
      end
   end

`ifndef SYNTHESIS
   // A command refused while busy leaves the sequencer untouched
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && (op != OP_TICK) && (phase_ff != PH_IDLE))
      |=> ($stable(phase_ff) && $stable(tick_ff) && $stable(bit_ff)))
      else $error("rejected command changed sequencer state");

   // Completion always lands in idle
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && result.done_res) |=> (phase_ff == PH_IDLE))
      else $error("done without returning to idle");

   // The slot timer is clear whenever idle
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("timer not clear in idle");
`endif

endmodule

@@ design/owm_out.sv @@
module owm_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  owm_pkg::result_type   push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output owm_pkg::result_type   pop_data
);
   import owm_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = main_valid_ff && pop_ready;
   assign push_ready = !skid_valid_ff;
   assign pop_valid  = main_valid_ff;
   assign pop_data   = main_ff;

   // Main register feeds the port; skid catches a transaction during a stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   // Skid entry is only ever occupied behind a full main register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds data with main register empty");
`endif

endmodule

@@ design/one_wire_bus_master.sv @@
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser op, tdata tx_byte and bus_level
// rsp      out        rsp_tvalid/rsp_tready  tdata line level and status, one per req
// csr      in         csr_we                 index and 10-bit timing value
//
// One req transaction per clock while req_tready is high; its rsp transaction appears
// in the cycle after acceptance unless older rsp transactions wait in the buffer.
// The sequencer state and output stage are single registers, so the rate is set by
// the output buffer alone: two entries, req_tready drops only when both are full.
// reset is synchronous; timing registers return to their default tick counts.
// Nothing to clear after reset; the block accepts transactions once reset is released.
module one_wire_bus_master #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [owm_pkg::REQ_DATA_W-1:0]      req_tdata,  // tx_byte[7:0], bus_level[8]
   input  logic [owm_pkg::OP_WIDTH-1:0]        req_tuser,  // op[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // line_low[0], busy_res[1], done_res[2], presence_level[3], rx_byte[11:4],
   // rejected[12]
   output logic [owm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [owm_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [owm_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import owm_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_result;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   owm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .op         (req_tuser),
      .tx_byte    (req_tdata[BYTE_WIDTH-1:0]),
      .bus_level  (req_tdata[BYTE_WIDTH]),
      .cfg        (cfg),
      .result     (result)
   );

   owm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_tready),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_result)
   );

   // Pack the result, last field lowest
   assign rsp_tdata = RSP_DATA_W'(rsp_result);

endmodule
